>>> hdl/fbpu_pkg.sv
// Shared types and constants of the framebuffer pixel unpacker.
package fbpu_pkg;

    localparam int unsigned PALETTE_ENTRIES = 256;
    localparam int unsigned PAL_IDX_W       = 8;
    localparam int unsigned PAL_WORD_W      = 24;
    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam int unsigned CFG_DATA_W      = 14;
    localparam int unsigned WIDTH_W         = 13;
    localparam int unsigned STRIDE_W        = 14;
    localparam int unsigned DEPTH_W         = 3;

    localparam logic [1:0] CFG_DEPTH_MODE    = 2'd0;
    localparam logic [1:0] CFG_VISIBLE_WIDTH = 2'd1;
    localparam logic [1:0] CFG_LINE_STRIDE   = 2'd2;

    localparam logic [DEPTH_W-1:0] MODE_1BPP  = 3'd0;
    localparam logic [DEPTH_W-1:0] MODE_2BPP  = 3'd1;
    localparam logic [DEPTH_W-1:0] MODE_4BPP  = 3'd2;
    localparam logic [DEPTH_W-1:0] MODE_8BPP  = 3'd3;
    localparam logic [DEPTH_W-1:0] MODE_16BPP = 3'd4;
    localparam logic [DEPTH_W-1:0] MODE_24BPP = 3'd5;
    localparam logic [DEPTH_W-1:0] MODE_32BPP = 3'd6;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic                  kind;
        logic [7:0]            fb_byte;
        logic [PAL_IDX_W-1:0]  palette_index;
        logic [PAL_WORD_W-1:0] palette_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_argb;
        logic        line_end;
        logic        last;
    } t_out_item;

    // One queued job: a palette write, or the pixels from one byte (or one gathered multi-byte pixel).
    typedef struct packed {
        logic                  is_wr;
        logic                  direct;
        logic [DEPTH_W-1:0]    mode;
        logic [3:0]            count;
        logic                  le_valid;
        logic [2:0]            le_pos;
        logic [PAL_IDX_W-1:0]  idx_or_byte;
        logic [PAL_WORD_W-1:0] word;
    } t_job;

endpackage

>>> hdl/framebuffer_pixel_unpacker_unit.sv
// Top level of the framebuffer pixel unpacker.
//
// Input channel (i_valid / o_stall, payload i_item): framebuffer bytes of a
// line in order, interleaved with palette writes. Output channel (o_valid /
// i_stall, payload o_item): opaque ARGB8888 pixels with line-end and last
// flags. Configuration is a plain write port, used only while idle.
// A transaction is accepted at a clock edge with valid high and stall low.
// The front end tracks the line and gathers multi-byte pixels, pushing a
// job per palette write and per byte that completes visible pixels into a
// four-entry queue; the back end emits one pixel per cycle unless i_stall
// holds it, reading the palette through a registered read port.
// Throughput: one transaction per cycle at 8 to 32 bpp and for palette
// writes while the queue has room; a 1, 2 or 4 bpp byte yields up to 8,
// 4 or 2 pixels, and the queue backpressures the input while they drain.
// Reset (synchronous, active low) restores the register defaults, clears
// line state, the queue and every palette valid bit at once; unwritten
// palette entries read as zero. While i_stall is high the output transaction
// holds and the queue keeps filling until full, then o_stall rises.
module framebuffer_pixel_unpacker_unit import fbpu_pkg::*; #(
    parameter int unsigned MAX_LINE_BYTES = 16384
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_item
);

    logic q_full;
    logic q_push;
    t_job q_in_job;
    logic q_valid;
    t_job q_head;
    logic q_pop;

    fbpu_front #(
        .MAX_LINE_BYTES(MAX_LINE_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_item     (i_item),
        .o_stall    (o_stall),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (q_in_job)
    );

    fbpu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_head),
        .i_pop   (q_pop)
    );

    fbpu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_head),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

endmodule

>>> hdl/fbpu_front.sv
// Front end: configuration, line tracking, byte gathering and job classification.
module fbpu_front import fbpu_pkg::*; #(
    parameter int unsigned MAX_LINE_BYTES = 16384
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  t_in_item              i_item,
    output logic                  o_stall,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_job                  o_job
);

    localparam int unsigned CNT_W = $clog2(MAX_LINE_BYTES);
    localparam int unsigned SUM_W = CNT_W + 1;
    localparam int unsigned CMP_W = (SUM_W > STRIDE_W) ? SUM_W : STRIDE_W;

    logic [DEPTH_W-1:0]  r_depth;
    logic [WIDTH_W-1:0]  r_vis_w;
    logic [STRIDE_W-1:0] r_stride;
    logic [CNT_W-1:0]    r_cnt;
    logic [WIDTH_W-1:0]  r_col;
    logic [23:0]         r_gather;
    logic [1:0]          r_phase;

    logic [SUM_W-1:0]    cnt_inc;
    logic                wrap;
    logic                accept;
    logic                byte_ok;
    logic [3:0]          ppb;
    logic                direct;
    logic [23:0]         color;
    logic [23:0]         gather_acc;
    logic [1:0]          phase_inc;
    logic                complete;
    logic [23:0]         n_gather;
    logic [1:0]          n_phase;
    logic [WIDTH_W-1:0]  remain;
    logic [3:0]          pix_cnt;
    logic [WIDTH_W-1:0]  n_col;
    logic                le_hit;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign byte_ok = !i_item.kind && (r_stride != '0);

    always_comb begin
        gather_acc = (r_phase == 2'd3) ? r_gather
                   : (r_gather | (24'(i_item.fb_byte) << {r_phase, 3'b000}));
        phase_inc  = r_phase + 2'd1;
        ppb        = 4'd0;
        direct     = 1'b0;
        complete   = 1'b0;
        n_gather   = r_gather;
        n_phase    = r_phase;
        unique case (r_depth)
            MODE_1BPP: begin
                ppb = 4'd8; n_gather = '0; n_phase = '0;
            end
            MODE_2BPP: begin
                ppb = 4'd4; n_gather = '0; n_phase = '0;
            end
            MODE_4BPP: begin
                ppb = 4'd2; n_gather = '0; n_phase = '0;
            end
            MODE_8BPP: begin
                ppb = 4'd1; n_gather = '0; n_phase = '0;
            end
            MODE_16BPP, MODE_24BPP, MODE_32BPP: begin
                direct   = 1'b1;
                complete = ({1'b0, phase_inc} >= (r_depth - MODE_8BPP + 3'd1))
                           || (phase_inc == 2'd0);
                ppb      = complete ? 4'd1 : 4'd0;
                n_gather = complete ? '0 : gather_acc;
                n_phase  = complete ? '0 : phase_inc;
            end
            default: begin
                ppb = 4'd0;
            end
        endcase
        if (r_depth == MODE_16BPP) begin
            color = {gather_acc[15:11], gather_acc[15:13],
                     gather_acc[10:5],  gather_acc[10:9],
                     gather_acc[4:0],   gather_acc[4:2]};
        end else begin
            color = gather_acc;
        end
    end

    always_comb begin
        remain = r_vis_w - r_col;
        if (r_col >= r_vis_w) begin
            pix_cnt = 4'd0;
        end else if (remain < WIDTH_W'(ppb)) begin
            pix_cnt = remain[3:0];
        end else begin
            pix_cnt = ppb;
        end
        n_col  = r_col + WIDTH_W'(pix_cnt);
        le_hit = (pix_cnt != 4'd0) && (n_col == r_vis_w);
    end

    assign cnt_inc = {1'b0, r_cnt} + SUM_W'(1);
    assign wrap    = (CMP_W'(cnt_inc) >= CMP_W'(r_stride))
                  || (cnt_inc >= SUM_W'(MAX_LINE_BYTES));

    assign o_push = accept && (i_item.kind || (byte_ok && (pix_cnt != 4'd0)));

    always_comb begin
        o_job             = '0;
        o_job.is_wr       = i_item.kind;
        o_job.direct      = direct;
        o_job.mode        = r_depth;
        o_job.count       = pix_cnt;
        o_job.le_valid    = le_hit;
        o_job.le_pos      = 3'(pix_cnt - 4'd1);
        o_job.idx_or_byte = i_item.kind ? i_item.palette_index : i_item.fb_byte;
        o_job.word        = i_item.kind ? i_item.palette_word : color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= MODE_16BPP;
            r_vis_w  <= '0;
            r_stride <= '0;
            r_cnt    <= '0;
            r_col    <= '0;
            r_gather <= '0;
            r_phase  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DEPTH_MODE:    r_depth  <= i_cfg_data[DEPTH_W-1:0];
                    CFG_VISIBLE_WIDTH: r_vis_w  <= i_cfg_data[WIDTH_W-1:0];
                    CFG_LINE_STRIDE:   r_stride <= i_cfg_data[STRIDE_W-1:0];
                    default: ;
                endcase
            end
            if (accept && byte_ok) begin
                if (wrap) begin
                    r_cnt    <= '0;
                    r_col    <= '0;
                    r_gather <= '0;
                    r_phase  <= '0;
                end else begin
                    r_cnt    <= cnt_inc[CNT_W-1:0];
                    r_col    <= n_col;
                    r_gather <= n_gather;
                    r_phase  <= n_phase;
                end
            end
        end
    end

endmodule

>>> hdl/fbpu_queue.sv
// Short job queue between the front end and the pixel emitter.
module fbpu_queue import fbpu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= PTR_W'(r_wr_ptr + PTR_W'(1));
            end
            if (i_pop) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + PTR_W'(1));
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

>>> hdl/fbpu_back.sv
// Back end: palette memory, one-pixel-per-cycle emitter (held while i_stall is high) and output register.
module fbpu_back import fbpu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic [PAL_WORD_W-1:0] r_pal_mem   [PALETTE_ENTRIES];
    logic                  r_pal_valid [PALETTE_ENTRIES];

    logic [2:0]            r_k;
    logic                  r_ovalid;
    logic                  r_direct;
    logic [23:0]           r_color;
    logic                  r_le;
    logic                  r_last;
    logic [PAL_WORD_W-1:0] r_rd_data;
    logic                  r_rd_ok;

    logic                  slot_free;
    logic                  do_wr;
    logic                  issue;
    logic                  final_pix;
    logic [7:0]            shifted;
    logic [PAL_IDX_W-1:0]  pix_idx;
    logic [23:0]           pal_rgb;

    assign slot_free = !r_ovalid || !i_stall;
    assign do_wr     = i_job_valid && i_job.is_wr;
    assign issue     = i_job_valid && !i_job.is_wr && slot_free;
    assign final_pix = ({1'b0, r_k} == (i_job.count - 4'd1));
    assign o_pop     = do_wr || (issue && final_pix);

    always_comb begin
        shifted = i_job.idx_or_byte << 3'(r_k << i_job.mode);
        unique case (i_job.mode)
            MODE_1BPP: pix_idx = {7'b0, shifted[7]};
            MODE_2BPP: pix_idx = {6'b0, shifted[7:6]};
            MODE_4BPP: pix_idx = {4'b0, shifted[7:4]};
            default:   pix_idx = shifted;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_pal_mem[i_job.idx_or_byte] <= i_job.word;
        end
        if (issue) begin
            r_rd_data <= r_pal_mem[pix_idx];
            r_rd_ok   <= r_pal_valid[pix_idx];
            r_direct  <= i_job.direct;
            r_color   <= i_job.word;
            r_le      <= i_job.le_valid && (r_k == i_job.le_pos);
            r_last    <= final_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                r_pal_valid[i] <= 1'b0;
            end
        end else begin
            if (do_wr) begin
                r_pal_valid[i_job.idx_or_byte] <= 1'b1;
            end
            if (issue) begin
                r_k <= final_pix ? 3'd0 : r_k + 3'd1;
            end
            if (slot_free) begin
                r_ovalid <= issue;
            end
        end
    end

    assign pal_rgb = r_rd_ok ? {r_rd_data[7:0], r_rd_data[15:8], r_rd_data[23:16]} : '0;

    assign o_valid           = r_ovalid;
    assign o_item.pixel_argb = {ALPHA_OPAQUE, r_direct ? r_color : pal_rgb};
    assign o_item.line_end   = r_le;
    assign o_item.last       = r_last;

endmodule
